@@ rtl/lked_pkg.sv @@
package lked_pkg;

   localparam int SAMPLE_W = 12;
   localparam int CODE_W = 4;
   localparam int SEQ_W = 8;
   localparam int MS_W = 16;
   localparam int THR_COUNT = 9;
   localparam int THR_FIRST_COUNT = 5;
   localparam int THR_FIRST_W = 60;
   localparam int THR_LAST_W = 48;
   localparam int MASK_W = 9;
   localparam int BUTTONS_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   localparam logic [CODE_W-1:0] IDLE_CODE = 4'd15;
   localparam logic [CODE_W-1:0] FAULT_CODE = 4'd14;

   localparam logic [MS_W-1:0] HOLD_RESET = 16'd200;
   localparam logic [MS_W-1:0] IDLE_RESET = 16'd1000;
   localparam logic [MS_W-1:0] COUNTER_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      EV_PRESS   = 3'd0,
      EV_RELEASE = 3'd1,
      EV_HOLD    = 3'd2,
      EV_FAULT   = 3'd3,
      EV_SLEEP   = 3'd4
   } event_kind_type;

   typedef enum logic [2:0] {
      REG_THR_FIRST = 3'd0,
      REG_THR_LAST  = 3'd1,
      REG_FAULT     = 3'd2,
      REG_REPEAT    = 3'd3,
      REG_HOLD      = 3'd4,
      REG_IDLE      = 3'd5,
      REG_BUTTONS   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                tick;
      logic [SAMPLE_W-1:0] median;
      logic [CODE_W-1:0]   code;
   } item_type;

endpackage

@@ rtl/lked_front.sv @@
module lked_front #(
   parameter int MAX_BUTTONS = 9
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_ready,
   input  logic                                             req_action,
   input  logic [lked_pkg::SAMPLE_W-1:0]                    req_reading_one,
   input  logic [lked_pkg::SAMPLE_W-1:0]                    req_reading_two,
   input  logic [lked_pkg::SAMPLE_W-1:0]                    req_reading_three,
   input  logic [MAX_BUTTONS-1:0][lked_pkg::SAMPLE_W-1:0]   thresholds,
   input  logic [lked_pkg::SAMPLE_W-1:0]                    fault_level,
   input  logic [lked_pkg::BUTTONS_W-1:0]                   buttons_in_use,
   output logic                                             push_valid,
   input  logic                                             push_ready,
   output lked_pkg::item_type                               push_item
);

   logic                               valid_ff;
   logic                               valid_in;
   lked_pkg::item_type                 item_ff;
   lked_pkg::item_type                 item_in;
   logic [lked_pkg::SAMPLE_W-1:0]      low_ab;
   logic [lked_pkg::SAMPLE_W-1:0]      high_ab;
   logic [lked_pkg::SAMPLE_W-1:0]      low_hc;
   logic [lked_pkg::SAMPLE_W-1:0]      median;
   logic [lked_pkg::BUTTONS_W-1:0]     checked;
   logic [lked_pkg::CODE_W-1:0]        code;

   assign req_ready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item = item_ff;

   always_comb begin
      low_ab = (req_reading_one < req_reading_two) ? req_reading_one : req_reading_two;
      high_ab = (req_reading_one < req_reading_two) ? req_reading_two : req_reading_one;
      low_hc = (high_ab < req_reading_three) ? high_ab : req_reading_three;
      median = (low_ab > low_hc) ? low_ab : low_hc;
   end

   always_comb begin
      checked = (buttons_in_use > lked_pkg::BUTTONS_W'(MAX_BUTTONS)) ?
                lked_pkg::BUTTONS_W'(MAX_BUTTONS) : buttons_in_use;
      code = lked_pkg::IDLE_CODE;
      for (int i = MAX_BUTTONS - 1; i >= 0; i--) begin
         if ((lked_pkg::BUTTONS_W'(i) < checked) && (median < thresholds[i])) begin
            code = lked_pkg::CODE_W'(i);
         end
      end
      if (median < fault_level) begin
         code = lked_pkg::FAULT_CODE;
      end
   end

   always_comb begin
      item_in.tick = req_action;
      item_in.median = median;
      item_in.code = code;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ rtl/lked_queue.sv @@
module lked_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  lked_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output lked_pkg::item_type pop_item
);

   localparam int DEPTH = 2;

   lked_pkg::item_type          slots_ff [DEPTH];
   logic                        wr_ptr_ff;
   logic                        wr_ptr_in;
   logic                        rd_ptr_ff;
   logic                        rd_ptr_in;
   logic [1:0]                  count_ff;
   logic [1:0]                  count_in;
   logic                        push_fire;
   logic                        pop_fire;

   assign push_ready = count_ff != 2'(DEPTH);
   assign pop_valid = count_ff != 2'd0;
   assign pop_item = slots_ff[rd_ptr_ff];
   assign push_fire = push_valid && push_ready;
   assign pop_fire = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_fire ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_fire ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 2'd1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push_fire) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count beyond depth");

   a_pointer_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'(DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

@@ rtl/lked_back.sv @@
module lked_back #(
   parameter int MAX_BUTTONS = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  lked_pkg::item_type               pop_item,
   input  logic [lked_pkg::MASK_W-1:0]      repeat_mask,
   input  logic [lked_pkg::MS_W-1:0]        hold_interval_ms,
   input  logic [lked_pkg::MS_W-1:0]        idle_timeout_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_event_kind,
   output logic [3:0]                       rsp_button_number,
   output logic                             rsp_button_present,
   output logic [lked_pkg::SEQ_W-1:0]       rsp_sequence_res,
   output logic [lked_pkg::SAMPLE_W-1:0]    rsp_median_reading
);

   logic [lked_pkg::CODE_W-1:0]     last_state_ff;
   logic [lked_pkg::CODE_W-1:0]     last_state_in;
   logic [lked_pkg::MS_W-1:0]       ms_ff;
   logic [lked_pkg::MS_W-1:0]       ms_in;
   logic                            any_sent_ff;
   logic                            any_sent_in;
   logic [lked_pkg::SEQ_W-1:0]      seq_ff;
   logic [lked_pkg::SEQ_W-1:0]      seq_in;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   lked_pkg::event_kind_type        kind_ff;
   lked_pkg::event_kind_type        kind_in;
   logic [3:0]                      button_ff;
   logic [3:0]                      button_in;
   logic                            present_ff;
   logic                            present_in;
   logic [lked_pkg::SEQ_W-1:0]      seq_out_ff;
   logic [lked_pkg::SEQ_W-1:0]      seq_out_in;
   logic [lked_pkg::SAMPLE_W-1:0]   median_ff;
   logic                            pop_fire;
   logic                            poll;
   logic                            changed;
   logic                            repeat_on;
   logic                            hold;
   logic                            sleep;
   logic                            emit;
   logic [lked_pkg::MASK_W-1:0]     mask_shifted;

   assign pop_ready = !out_valid_ff || rsp_ready;
   assign pop_fire = pop_valid && pop_ready;
   assign poll = !pop_item.tick;

   assign rsp_valid = out_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_button_number = button_ff;
   assign rsp_button_present = present_ff;
   assign rsp_sequence_res = seq_out_ff;
   assign rsp_median_reading = median_ff;

   always_comb begin
      mask_shifted = repeat_mask >> pop_item.code;
      changed = pop_item.code != last_state_ff;
      repeat_on = (pop_item.code < lked_pkg::CODE_W'(MAX_BUTTONS)) && mask_shifted[0];
      hold = !changed && repeat_on && any_sent_ff && (ms_ff > hold_interval_ms);
      sleep = !changed && (pop_item.code == lked_pkg::IDLE_CODE) &&
              (ms_ff > idle_timeout_ms);
      emit = poll && (changed || hold || sleep);

      last_state_in = last_state_ff;
      ms_in = ms_ff;
      any_sent_in = any_sent_ff;
      seq_in = seq_ff;
      kind_in = lked_pkg::EV_SLEEP;
      button_in = 4'd0;
      present_in = 1'b0;

      if (pop_item.tick) begin
         if (ms_ff != lked_pkg::COUNTER_MAX) begin
            ms_in = ms_ff + 16'd1;
         end
      end else if (changed || hold) begin
         last_state_in = pop_item.code;
         ms_in = '0;
         any_sent_in = 1'b1;
         seq_in = seq_ff + 8'd1;
      end

      if (changed) begin
         if (pop_item.code == lked_pkg::IDLE_CODE) begin
            kind_in = lked_pkg::EV_RELEASE;
         end else if (pop_item.code == lked_pkg::FAULT_CODE) begin
            kind_in = lked_pkg::EV_FAULT;
         end else begin
            kind_in = lked_pkg::EV_PRESS;
            button_in = pop_item.code;
            present_in = 1'b1;
         end
      end else if (hold) begin
         kind_in = lked_pkg::EV_HOLD;
         button_in = pop_item.code;
         present_in = 1'b1;
      end
      seq_out_in = seq_in;

      if (pop_fire) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_state_ff <= lked_pkg::IDLE_CODE;
         ms_ff <= '0;
         any_sent_ff <= 1'b0;
         seq_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop_fire) begin
            last_state_ff <= last_state_in;
            ms_ff <= ms_in;
            any_sent_ff <= any_sent_in;
            seq_ff <= seq_in;
         end
      end
      if (pop_fire && emit) begin
         kind_ff <= kind_in;
         button_ff <= button_in;
         present_ff <= present_in;
         seq_out_ff <= seq_out_in;
         median_ff <= pop_item.median;
      end
   end

   a_present_kind: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && present_ff) |-> (kind_ff == lked_pkg::EV_PRESS ||
                                        kind_ff == lked_pkg::EV_HOLD))
      else $error("button present on an event without a button");

   a_sleep_idle: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && emit && sleep) |=> (last_state_ff == lked_pkg::IDLE_CODE &&
                                       seq_ff == $past(seq_ff)))
      else $error("sleep request outside idle or with sequence bump");

   a_event_sequence: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && poll && (changed || hold)) |=>
         (seq_ff == 8'($past(seq_ff) + 8'd1) && ms_ff == '0 && any_sent_ff))
      else $error("event did not advance sequence state");

endmodule

@@ rtl/ladder_keypad_event_decoder_top.sv @@
// Resistor-ladder keypad decoder.
// The req channel takes one word per cycle while req_ready is high: a poll (action 0)
// with three ADC readings, or a one millisecond tick (action 1). The rsp channel
// returns at most one event word per poll: press, release, hold, fault or sleep
// request, with the button, the sequence number and the median of the poll's readings.
// A poll passes a classify stage (median and band compare), a two-word queue and
// an event stage that owns the keypad state and the output register. With rsp_ready
// high, an event word passes the classify register, a queue slot and the output
// register, and one word per cycle is sustained in both directions.
// When the receiver stalls, the output register holds its word, the queue fills and
// req_ready falls only once the classify stage and the queue are both full.
// Reset, synchronous and active high, empties the pipeline, sets the decoded state to
// idle, clears the millisecond counter and the sequence number, and loads the
// register defaults (hold 200 ms, idle timeout 1000 ms, all buttons in use).
// Registers sit on a 64-bit port at byte address 8 times their index. The user must
// write them only while no word is in flight; the block itself does not enforce it.
module ladder_keypad_event_decoder_top #(
   parameter int MAX_BUTTONS = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [lked_pkg::SAMPLE_W-1:0]       req_reading_one,
   input  logic [lked_pkg::SAMPLE_W-1:0]       req_reading_two,
   input  logic [lked_pkg::SAMPLE_W-1:0]       req_reading_three,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_event_kind,
   output logic [3:0]                          rsp_button_number,
   output logic                                rsp_button_present,
   output logic [lked_pkg::SEQ_W-1:0]          rsp_sequence_res,
   output logic [lked_pkg::SAMPLE_W-1:0]       rsp_median_reading,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lked_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lked_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lked_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [lked_pkg::THR_FIRST_W-1:0]                        thr_first_ff;
   logic [lked_pkg::THR_LAST_W-1:0]                         thr_last_ff;
   logic [lked_pkg::SAMPLE_W-1:0]                           fault_ff;
   logic [lked_pkg::MASK_W-1:0]                             repeat_ff;
   logic [lked_pkg::MS_W-1:0]                               hold_ff;
   logic [lked_pkg::MS_W-1:0]                               idle_ff;
   logic [lked_pkg::BUTTONS_W-1:0]                          buttons_ff;
   logic                                                    csr_write;
   lked_pkg::csr_index_type                                 csr_index;
   logic [lked_pkg::THR_COUNT-1:0][lked_pkg::SAMPLE_W-1:0]  thresholds;
   logic                                                    push_valid;
   logic                                                    push_ready;
   lked_pkg::item_type                                      push_item;
   logic                                                    pop_valid;
   logic                                                    pop_ready;
   lked_pkg::item_type                                      pop_item;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = lked_pkg::csr_index_type'(csr_paddr[lked_pkg::CSR_ADDR_W-1:3]);

   always_comb begin
      for (int i = 0; i < lked_pkg::THR_FIRST_COUNT; i++) begin
         thresholds[i] = thr_first_ff[lked_pkg::SAMPLE_W*i +: lked_pkg::SAMPLE_W];
      end
      for (int i = 0; i < lked_pkg::THR_COUNT - lked_pkg::THR_FIRST_COUNT; i++) begin
         thresholds[lked_pkg::THR_FIRST_COUNT + i] =
            thr_last_ff[lked_pkg::SAMPLE_W*i +: lked_pkg::SAMPLE_W];
      end
   end

   always_comb begin
      unique case (csr_index)
         lked_pkg::REG_THR_FIRST: csr_prdata = lked_pkg::CSR_DATA_W'(thr_first_ff);
         lked_pkg::REG_THR_LAST:  csr_prdata = lked_pkg::CSR_DATA_W'(thr_last_ff);
         lked_pkg::REG_FAULT:     csr_prdata = lked_pkg::CSR_DATA_W'(fault_ff);
         lked_pkg::REG_REPEAT:    csr_prdata = lked_pkg::CSR_DATA_W'(repeat_ff);
         lked_pkg::REG_HOLD:      csr_prdata = lked_pkg::CSR_DATA_W'(hold_ff);
         lked_pkg::REG_IDLE:      csr_prdata = lked_pkg::CSR_DATA_W'(idle_ff);
         lked_pkg::REG_BUTTONS:   csr_prdata = lked_pkg::CSR_DATA_W'(buttons_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_first_ff <= '0;
         thr_last_ff <= '0;
         fault_ff <= '0;
         repeat_ff <= '0;
         hold_ff <= lked_pkg::HOLD_RESET;
         idle_ff <= lked_pkg::IDLE_RESET;
         buttons_ff <= lked_pkg::BUTTONS_W'(MAX_BUTTONS);
      end else if (csr_write) begin
         unique case (csr_index)
            lked_pkg::REG_THR_FIRST: thr_first_ff <= csr_pwdata[lked_pkg::THR_FIRST_W-1:0];
            lked_pkg::REG_THR_LAST:  thr_last_ff <= csr_pwdata[lked_pkg::THR_LAST_W-1:0];
            lked_pkg::REG_FAULT:     fault_ff <= csr_pwdata[lked_pkg::SAMPLE_W-1:0];
            lked_pkg::REG_REPEAT:    repeat_ff <= csr_pwdata[lked_pkg::MASK_W-1:0];
            lked_pkg::REG_HOLD:      hold_ff <= csr_pwdata[lked_pkg::MS_W-1:0];
            lked_pkg::REG_IDLE:      idle_ff <= csr_pwdata[lked_pkg::MS_W-1:0];
            lked_pkg::REG_BUTTONS:   buttons_ff <= csr_pwdata[lked_pkg::BUTTONS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lked_front #(
      .MAX_BUTTONS(MAX_BUTTONS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_reading_one   (req_reading_one),
      .req_reading_two   (req_reading_two),
      .req_reading_three (req_reading_three),
      .thresholds        (thresholds[MAX_BUTTONS-1:0]),
      .fault_level       (fault_ff),
      .buttons_in_use    (buttons_ff),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_item         (push_item)
   );

   lked_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   lked_back #(
      .MAX_BUTTONS(MAX_BUTTONS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_item           (pop_item),
      .repeat_mask        (repeat_ff),
      .hold_interval_ms   (hold_ff),
      .idle_timeout_ms    (idle_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_button_number  (rsp_button_number),
      .rsp_button_present (rsp_button_present),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_median_reading (rsp_median_reading)
   );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam bit ACT_POLL = 1'b0;
   localparam bit ACT_TICK = 1'b1;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 12;
   localparam int WORDS_PER_PHASE = 136;

   typedef struct {
      lked_pkg::event_kind_type      kind;
      logic [3:0]                    button;
      logic                          present;
      logic [lked_pkg::SEQ_W-1:0]    seq;
      logic [lked_pkg::SAMPLE_W-1:0] median;
   } keypad_event_type;

   class keypad_event_ledger;
      logic [lked_pkg::THR_FIRST_W-1:0] thr_first;
      logic [lked_pkg::THR_LAST_W-1:0]  thr_last;
      logic [lked_pkg::SAMPLE_W-1:0]    fault_lvl;
      logic [lked_pkg::MASK_W-1:0]      repeat_bits;
      logic [lked_pkg::MS_W-1:0]        hold_ms;
      logic [lked_pkg::MS_W-1:0]        idle_ms;
      logic [lked_pkg::BUTTONS_W-1:0]   buttons_used;
      logic [lked_pkg::CODE_W-1:0]      decoded;
      logic [lked_pkg::MS_W-1:0]        ms_count;
      logic                             sent_any;
      logic [lked_pkg::SEQ_W-1:0]       seq_num;
      int                               errors;
      keypad_event_type                 awaited[$];

      function new();
         thr_first = '0;
         thr_last = '0;
         fault_lvl = '0;
         repeat_bits = '0;
         hold_ms = lked_pkg::HOLD_RESET;
         idle_ms = lked_pkg::IDLE_RESET;
         buttons_used = lked_pkg::BUTTONS_W'(lked_pkg::THR_COUNT);
         decoded = lked_pkg::IDLE_CODE;
         ms_count = '0;
         sent_any = 1'b0;
         seq_num = '0;
         errors = 0;
      endfunction

      function void set_reg(lked_pkg::csr_index_type idx,
                            logic [lked_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            lked_pkg::REG_THR_FIRST: thr_first = value[lked_pkg::THR_FIRST_W-1:0];
            lked_pkg::REG_THR_LAST:  thr_last = value[lked_pkg::THR_LAST_W-1:0];
            lked_pkg::REG_FAULT:     fault_lvl = value[lked_pkg::SAMPLE_W-1:0];
            lked_pkg::REG_REPEAT:    repeat_bits = value[lked_pkg::MASK_W-1:0];
            lked_pkg::REG_HOLD:      hold_ms = value[lked_pkg::MS_W-1:0];
            lked_pkg::REG_IDLE:      idle_ms = value[lked_pkg::MS_W-1:0];
            lked_pkg::REG_BUTTONS:   buttons_used = value[lked_pkg::BUTTONS_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [lked_pkg::SAMPLE_W-1:0] threshold(int i);
         if (i < lked_pkg::THR_FIRST_COUNT)
            return thr_first[lked_pkg::SAMPLE_W*i +: lked_pkg::SAMPLE_W];
         return thr_last[lked_pkg::SAMPLE_W*(i-lked_pkg::THR_FIRST_COUNT) +:
                         lked_pkg::SAMPLE_W];
      endfunction

      function int buttons_checked();
         int n;
         n = buttons_used;
         if (n > lked_pkg::THR_COUNT)
            n = lked_pkg::THR_COUNT;
         return n;
      endfunction

      function logic [lked_pkg::CODE_W-1:0] decode(logic [lked_pkg::SAMPLE_W-1:0] m);
         if (m < fault_lvl)
            return lked_pkg::FAULT_CODE;
         for (int i = 0; i < buttons_checked(); i++)
            if (m < threshold(i))
               return lked_pkg::CODE_W'(i);
         return lked_pkg::IDLE_CODE;
      endfunction

      function logic [lked_pkg::SAMPLE_W-1:0] median_of(int a, int b, int c);
         int hi, lo;
         hi = a;
         lo = a;
         if (b > hi) hi = b;
         if (c > hi) hi = c;
         if (b < lo) lo = b;
         if (c < lo) lo = c;
         return lked_pkg::SAMPLE_W'(a + b + c - hi - lo);
      endfunction

      function void push(lked_pkg::event_kind_type kind, logic [3:0] button, logic present,
                         logic [lked_pkg::SAMPLE_W-1:0] m);
         keypad_event_type e;
         e.kind = kind;
         e.button = button;
         e.present = present;
         e.seq = seq_num;
         e.median = m;
         awaited.push_back(e);
      endfunction

      function void bump();
         seq_num = seq_num + 1'b1;
         ms_count = '0;
         sent_any = 1'b1;
      endfunction

      function void note_word(logic action, logic [lked_pkg::SAMPLE_W-1:0] r1,
                              logic [lked_pkg::SAMPLE_W-1:0] r2,
                              logic [lked_pkg::SAMPLE_W-1:0] r3);
         logic [lked_pkg::SAMPLE_W-1:0] m;
         logic [lked_pkg::CODE_W-1:0]   cur;
         if (action == ACT_TICK) begin
            if (ms_count != lked_pkg::COUNTER_MAX)
               ms_count = ms_count + 1'b1;
            return;
         end
         m = median_of(r1, r2, r3);
         cur = decode(m);
         if (cur != decoded) begin
            decoded = cur;
            bump();
            if (cur == lked_pkg::IDLE_CODE)
               push(lked_pkg::EV_RELEASE, 4'd0, 1'b0, m);
            else if (cur == lked_pkg::FAULT_CODE)
               push(lked_pkg::EV_FAULT, 4'd0, 1'b0, m);
            else
               push(lked_pkg::EV_PRESS, cur, 1'b1, m);
         end else if (cur < lked_pkg::THR_COUNT && repeat_bits[cur] && sent_any &&
                      ms_count > hold_ms) begin
            bump();
            push(lked_pkg::EV_HOLD, cur, 1'b1, m);
         end else if (cur == lked_pkg::IDLE_CODE && ms_count > idle_ms) begin
            // A sleep request leaves the sequence number and the counter alone.
            push(lked_pkg::EV_SLEEP, 4'd0, 1'b0, m);
         end
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_word(logic [2:0] kind, logic [3:0] button, logic present,
                               logic [lked_pkg::SEQ_W-1:0] seq,
                               logic [lked_pkg::SAMPLE_W-1:0] median);
         keypad_event_type e;
         if (awaited.size() == 0) begin
            $display({"%0t: unexpected event word, expected none, ",
                      "actual kind %0d button %0d seq %0d median %0d"},
                     $time, kind, button, seq, median);
            errors++;
            return;
         end
         e = awaited.pop_front();
         compare_field("event_kind", e.kind, kind);
         compare_field("button_number", e.button, button);
         compare_field("button_present", e.present, present);
         compare_field("sequence_res", e.seq, seq);
         compare_field("median_reading", e.median, median);
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic                            req_action;
   logic [lked_pkg::SAMPLE_W-1:0]   req_reading_one;
   logic [lked_pkg::SAMPLE_W-1:0]   req_reading_two;
   logic [lked_pkg::SAMPLE_W-1:0]   req_reading_three;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic [2:0]                      rsp_event_kind;
   logic [3:0]                      rsp_button_number;
   logic                            rsp_button_present;
   logic [lked_pkg::SEQ_W-1:0]      rsp_sequence_res;
   logic [lked_pkg::SAMPLE_W-1:0]   rsp_median_reading;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [lked_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [lked_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [lked_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   keypad_event_ledger ledger;
   int sender_idle_pct;
   int stall_pct;
   int cycle_count;

   ladder_keypad_event_decoder_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_reading_one(req_reading_one),
      .req_reading_two(req_reading_two),
      .req_reading_three(req_reading_three),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_kind(rsp_event_kind),
      .rsp_button_number(rsp_button_number),
      .rsp_button_present(rsp_button_present),
      .rsp_sequence_res(rsp_sequence_res),
      .rsp_median_reading(rsp_median_reading),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_word(rsp_event_kind, rsp_button_number, rsp_button_present,
                           rsp_sequence_res, rsp_median_reading);

   task automatic send_word(logic action, logic [lked_pkg::SAMPLE_W-1:0] r1,
                            logic [lked_pkg::SAMPLE_W-1:0] r2,
                            logic [lked_pkg::SAMPLE_W-1:0] r3);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_reading_one <= r1;
      req_reading_two <= r2;
      req_reading_three <= r3;
      forever begin
         @(posedge clock);
         if (req_ready)
            break;
      end
      ledger.note_word(action, r1, r2, r3);
   endtask

   task automatic send_tick();
      send_word(ACT_TICK, lked_pkg::SAMPLE_W'($urandom), lked_pkg::SAMPLE_W'($urandom),
                lked_pkg::SAMPLE_W'($urandom));
   endtask

   // The other two readings straddle the median, either close to it or anywhere.
   task automatic send_poll(logic [lked_pkg::SAMPLE_W-1:0] v);
      logic [lked_pkg::SAMPLE_W-1:0] lo_r, hi_r;
      int down, up;
      if ($urandom_range(1)) begin
         down = (v < 24) ? v : 24;
         up = (4095 - v < 24) ? 4095 - v : 24;
         lo_r = v - $urandom_range(down);
         hi_r = v + $urandom_range(up);
      end else begin
         lo_r = $urandom_range(v);
         hi_r = $urandom_range(4095, v);
      end
      case ($urandom_range(5))
         0: send_word(ACT_POLL, v, lo_r, hi_r);
         1: send_word(ACT_POLL, lo_r, v, hi_r);
         2: send_word(ACT_POLL, hi_r, lo_r, v);
         3: send_word(ACT_POLL, lo_r, hi_r, v);
         4: send_word(ACT_POLL, v, hi_r, lo_r);
         default: send_word(ACT_POLL, hi_r, v, lo_r);
      endcase
   endtask

   // Button k below the checked count, idle at the count, fault one above it.
   function automatic logic [lked_pkg::SAMPLE_W-1:0] band_median(int k);
      int n, lo, hi;
      n = ledger.buttons_checked();
      if (k > n) begin
         if (ledger.fault_lvl == 0)
            return $urandom_range(4095);
         return $urandom_range(ledger.fault_lvl - 1);
      end
      lo = ledger.fault_lvl;
      hi = 4095;
      for (int j = 0; j < k && j < n; j++)
         if (ledger.threshold(j) > lo)
            lo = ledger.threshold(j);
      if (k < n)
         hi = ledger.threshold(k) - 1;
      if (lo > hi)
         return $urandom_range(4095);
      return $urandom_range(hi, lo);
   endfunction

   task automatic csr_write(lked_pkg::csr_index_type idx,
                            logic [lked_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_pready)
            break;
      end
      ledger.set_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_phase(int p);
      logic [lked_pkg::SAMPLE_W-1:0]    t [lked_pkg::THR_COUNT];
      logic [lked_pkg::THR_FIRST_W-1:0] first;
      logic [lked_pkg::THR_LAST_W-1:0]  last;
      int level;
      level = $urandom_range(150);
      for (int i = 0; i < lked_pkg::THR_COUNT; i++) begin
         if (p == 1) begin
            t[i] = '1;
         end else if (p == 0 || p == 2 || p == 7) begin
            t[i] = lked_pkg::SAMPLE_W'($urandom);
            if (i > 0 && $urandom_range(3) == 0)
               t[i] = t[i-1];
         end else begin
            level = level + $urandom_range(440, 60);
            t[i] = (level > 4095) ? 12'hFFF : lked_pkg::SAMPLE_W'(level);
         end
      end
      first = '0;
      last = '0;
      for (int i = 0; i < lked_pkg::THR_COUNT; i++)
         if (i < lked_pkg::THR_FIRST_COUNT)
            first[lked_pkg::SAMPLE_W*i +: lked_pkg::SAMPLE_W] = t[i];
         else
            last[lked_pkg::SAMPLE_W*(i-lked_pkg::THR_FIRST_COUNT) +:
                 lked_pkg::SAMPLE_W] = t[i];
      csr_write(lked_pkg::REG_THR_FIRST, first);
      csr_write(lked_pkg::REG_THR_LAST, last);
      if (p == 0) begin
         csr_write(lked_pkg::REG_FAULT, 0);
         csr_write(lked_pkg::REG_REPEAT, 0);
         csr_write(lked_pkg::REG_HOLD, 0);
         csr_write(lked_pkg::REG_IDLE, 0);
         csr_write(lked_pkg::REG_BUTTONS, 0);
      end else if (p == 1) begin
         csr_write(lked_pkg::REG_FAULT, 12'hFFF);
         csr_write(lked_pkg::REG_REPEAT, 9'h1FF);
         csr_write(lked_pkg::REG_HOLD, 16'hFFFF);
         csr_write(lked_pkg::REG_IDLE, 16'hFFFF);
         csr_write(lked_pkg::REG_BUTTONS, 4'hF);
      end else begin
         csr_write(lked_pkg::REG_FAULT,
                   (p == 2 || p == 7) ? $urandom_range(300) : $urandom_range(150));
         csr_write(lked_pkg::REG_REPEAT, $urandom_range(511));
         csr_write(lked_pkg::REG_HOLD, $urandom_range(6));
         csr_write(lked_pkg::REG_IDLE, $urandom_range(12));
         csr_write(lked_pkg::REG_BUTTONS, $urandom_range(lked_pkg::THR_COUNT, 1));
      end
   endtask

   // Mostly whole gestures: a band held over several polls with ticks between them.
   task automatic run_phase();
      int sent, choice, n, k, reps, ticks, hold_cap;
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
         choice = $urandom_range(99);
         n = ledger.buttons_checked();
         hold_cap = (ledger.hold_ms > 10) ? 10 : ledger.hold_ms;
         if (choice < 12) begin
            send_word(ACT_POLL, lked_pkg::SAMPLE_W'($urandom), lked_pkg::SAMPLE_W'($urandom),
                      lked_pkg::SAMPLE_W'($urandom));
            sent++;
         end else if (choice < 25) begin
            ticks = $urandom_range(hold_cap + 3, 1);
            repeat (ticks) send_tick();
            sent += ticks;
         end else begin
            k = $urandom_range(n + 1);
            reps = $urandom_range(4, 1);
            repeat (reps) begin
               send_poll(band_median(k));
               ticks = $urandom_range(hold_cap + 2);
               repeat (ticks) send_tick();
               sent += 1 + ticks;
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      cycle_count = 0;
      sender_idle_pct = 0;
      stall_pct = 0;
      req_valid = 1'b0;
      req_action = ACT_POLL;
      req_reading_one = '0;
      req_reading_two = '0;
      req_reading_three = '0;
      rsp_ready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      ledger = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(lked_pkg::REG_THR_FIRST, {12'd2000, 12'd1600, 12'd1200, 12'd800, 12'd400});
      csr_write(lked_pkg::REG_THR_LAST, {12'd3600, 12'd3200, 12'd2800, 12'd2400});
      csr_write(lked_pkg::REG_FAULT, 100);
      csr_write(lked_pkg::REG_REPEAT, 9'h155);
      csr_write(lked_pkg::REG_HOLD, 3);
      csr_write(lked_pkg::REG_IDLE, 5);
      csr_write(lked_pkg::REG_BUTTONS, lked_pkg::THR_COUNT);

      send_word(ACT_POLL, 0, 0, 0);
      send_word(ACT_POLL, 4095, 4095, 4095);
      send_word(ACT_POLL, 350, 120, 4095);
      repeat (4) send_tick();
      send_word(ACT_POLL, 399, 300, 100);
      send_word(ACT_POLL, 0, 3500, 4095);
      send_word(ACT_POLL, 3599, 3599, 3599);
      send_word(ACT_POLL, 2000, 4095, 0);
      send_word(ACT_POLL, 99, 4095, 99);
      send_word(ACT_POLL, 100, 100, 100);
      send_word(ACT_POLL, 4000, 3700, 4095);
      repeat (6) send_tick();
      send_word(ACT_POLL, 3601, 3601, 3601);
      send_word(ACT_POLL, 4095, 0, 4095);
      send_word(ACT_POLL, 1, 2, 4094);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         configure_phase(p);
         case (p % 4)
            0: begin
               sender_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 59;
               stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct = 59;
            end
            default: begin
               sender_idle_pct = 12;
               stall_pct = 12;
            end
         endcase
         run_phase();
         settle();
      end

      if (ledger.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/lked_pkg.sv
rtl/lked_front.sv
rtl/lked_queue.sv
rtl/lked_back.sv
rtl/ladder_keypad_event_decoder_top.sv
tb/tb.sv
